>>> rtl/core/cvh_pkg.sv
// Shared constants, types and helpers for the convex hull block.
package cvh_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;
    localparam int HULL_DEPTH = 2 * MAX_POINTS;
    localparam int PIDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int HIDX_W     = $clog2(HULL_DEPTH);
    localparam int K_W        = $clog2(HULL_DEPTH + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int QDEPTH     = 4;
    localparam int QIDX_W     = $clog2(QDEPTH);
    localparam int QLVL_W     = $clog2(QDEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord y;
        t_coord z;
    } t_point;

    // One queued request: a point and whether it closes the set.
    typedef struct packed {
        t_point pt;
        logic   close;
    } t_cmd;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              push;
        logic              pop;
    } t_qstat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_HFETCH,
        S_HLOAD,
        S_HTEST,
        S_HCMP,
        S_HPOP,
        S_ORD,
        S_OLD
    } t_state;

    function automatic logic pt_less(input t_point a, input t_point b);
        logic res;
        if (a.y != b.y) begin
            res = (a.y < b.y);
        end else begin
            res = (a.z < b.z);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/cvh_if.sv
// Handshake interfaces for point requests and hull vertex results.
interface cvh_pt_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cvh_pkg::COORD_BITS-1:0] point_y;
    logic signed [cvh_pkg::COORD_BITS-1:0] point_z;
    logic                                 set_end;

    modport source (output valid, output point_y, output point_z, output set_end,
                    input ready);
    modport sink   (input valid, input point_y, input point_z, input set_end,
                    output ready);
endinterface

interface cvh_hull_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cvh_pkg::COORD_BITS-1:0] hull_y;
    logic signed [cvh_pkg::COORD_BITS-1:0] hull_z;
    logic                                 hull_last;
    logic                                 dropped;

    modport source (output valid, output hull_y, output hull_z, output hull_last,
                    output dropped, input ready);
    modport sink   (input valid, input hull_y, input hull_z, input hull_last,
                    input dropped, output ready);
endinterface

>>> rtl/core/cvh_front.sv
// Front end: takes point requests, tags set closes, queues them for the back end.
module cvh_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cvh_pt_if.sink        i_pt,
    output cvh_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output cvh_pkg::t_qstat o_stat
);
    import cvh_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QIDX_W-1:0] r_wp, n_wp;
    logic [QIDX_W-1:0] r_rp, n_rp;
    logic [QLVL_W-1:0] r_lvl, n_lvl;
    logic              push, pop;
    t_cmd              cmd_in;

    assign i_pt.ready   = (r_lvl != QLVL_W'(QDEPTH));
    assign push         = i_pt.valid && i_pt.ready;
    assign o_cmd_valid  = (r_lvl != '0);
    assign pop          = o_cmd_valid && i_cmd_ready;
    assign o_cmd        = r_q[r_rp];
    assign cmd_in.pt.y  = i_pt.point_y;
    assign cmd_in.pt.z  = i_pt.point_z;
    assign cmd_in.close = i_pt.set_end;

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_lvl = r_lvl + QLVL_W'(push) - QLVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_lvl <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_lvl <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_stat.level = r_lvl;
    assign o_stat.push  = push;
    assign o_stat.pop   = pop;

endmodule

>>> rtl/core/cvh_back.sv
// Back end: insertion-sorted point store, monotone chain hull build, vertex output.
module cvh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cvh_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    cvh_hull_if.source    o_hull
);
    import cvh_pkg::*;

    t_point r_pmem [MAX_POINTS];
    t_point r_hmem [HULL_DEPTH];

    t_state r_st, n_st;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic              r_close, n_close;
    t_point            r_key, n_key;
    logic [PIDX_W-1:0] r_j, n_j;
    logic [PIDX_W-1:0] r_i, n_i;
    logic              r_up, n_up;
    logic [K_W-1:0]    r_k, n_k;
    logic [K_W-1:0]    r_lim, n_lim;
    logic              r_keep, n_keep;
    t_point            r_a, n_a;
    t_point            r_b, n_b;
    t_point            r_p, n_p;
    logic signed [PROD_W-1:0] r_m1, n_m1, r_m2, n_m2;
    logic [HIDX_W-1:0] r_o, n_o;
    logic [K_W-1:0]    r_len, n_len;

    logic              r_ov, n_ov;
    t_point            r_ovpt, n_ovpt;
    logic              r_olast, n_olast;
    logic              r_odrop, n_odrop;

    // Memory ports
    logic [PIDX_W-1:0] praddr;
    t_point            r_prd;
    logic              pwe;
    logic [PIDX_W-1:0] pwaddr;
    t_point            pwdata;
    logic [HIDX_W-1:0] hraddr;
    t_point            r_hrd;
    logic              hwe;
    t_point            hwdata;

    logic signed [DIFF_W-1:0] d_by, d_bz, d_py, d_pz;
    logic [K_W-1:0]    k_push;
    logic [CNT_W-1:0]  nm1;
    logic              slot_free;

    assign d_by = DIFF_W'(r_b.y) - DIFF_W'(r_a.y);
    assign d_bz = DIFF_W'(r_b.z) - DIFF_W'(r_a.z);
    assign d_py = DIFF_W'(r_p.y) - DIFF_W'(r_a.y);
    assign d_pz = DIFF_W'(r_p.z) - DIFF_W'(r_a.z);
    assign k_push    = r_k + 1'b1;
    assign nm1       = r_cnt - 1'b1;
    assign slot_free = !r_ov || o_hull.ready;

    always_comb begin
        n_st = r_st;   n_cnt = r_cnt; n_ovf = r_ovf; n_close = r_close;
        n_key = r_key; n_j = r_j;     n_i = r_i;     n_up = r_up;
        n_k = r_k;     n_lim = r_lim; n_a = r_a;     n_b = r_b;
        n_p = r_p;     n_m1 = r_m1;   n_m2 = r_m2;   n_o = r_o;
        n_len = r_len; n_ovpt = r_ovpt; n_olast = r_olast; n_odrop = r_odrop;
        n_keep = r_keep;
        n_ov = r_ov && !o_hull.ready;
        o_cmd_ready = 1'b0;
        praddr = r_i;
        pwe    = 1'b0;
        pwaddr = r_j;
        pwdata = r_key;
        hraddr = r_o;
        hwe    = 1'b0;
        hwdata = r_p;

        unique case (r_st)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_close = i_cmd.close;
                    if (r_cnt == CNT_W'(MAX_POINTS)) begin
                        n_ovf = 1'b1;
                        if (i_cmd.close) begin
                            n_i = '0; n_k = '0; n_up = 1'b0; n_lim = K_W'(2);
                            n_st = S_HFETCH;
                        end
                    end else begin
                        n_key = i_cmd.pt;
                        n_j   = PIDX_W'(r_cnt);
                        n_st  = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                praddr = r_j - 1'b1;
                if (r_j == '0) begin
                    pwe   = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (r_close) begin
                        n_i = '0; n_k = '0; n_up = 1'b0; n_lim = K_W'(2);
                        n_st = S_HFETCH;
                    end else begin
                        n_st = S_IDLE;
                    end
                end else begin
                    n_st = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                pwe = 1'b1;
                if (pt_less(r_key, r_prd)) begin
                    pwdata = r_prd;
                    n_j    = r_j - 1'b1;
                    n_st   = S_INS_RD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_close) begin
                        n_i = '0; n_k = '0; n_up = 1'b0; n_lim = K_W'(2);
                        n_st = S_HFETCH;
                    end else begin
                        n_st = S_IDLE;
                    end
                end
            end
            S_HFETCH: begin
                n_st = S_HLOAD;
            end
            S_HLOAD: begin
                n_p  = r_prd;
                n_st = S_HTEST;
            end
            S_HTEST: begin
                if (r_k >= r_lim && !r_keep) begin
                    n_m1 = d_by * d_pz;
                    n_m2 = d_bz * d_py;
                    n_st = S_HCMP;
                end else begin
                    // push the point and move to the next one
                    hwe    = 1'b1;
                    n_keep = 1'b0;
                    n_a = r_b;
                    n_b = r_p;
                    n_k = k_push;
                    if (!r_up) begin
                        if (CNT_W'(r_i) == nm1) begin
                            n_up  = 1'b1;
                            n_lim = k_push + 1'b1;
                            if (r_cnt < CNT_W'(2)) begin
                                n_len = k_push; n_o = '0; n_st = S_ORD;
                            end else begin
                                n_i  = PIDX_W'(r_cnt - CNT_W'(2));
                                n_st = S_HFETCH;
                            end
                        end else begin
                            n_i  = r_i + 1'b1;
                            n_st = S_HFETCH;
                        end
                    end else if (r_i == '0) begin
                        n_len = k_push; n_o = '0; n_st = S_ORD;
                    end else begin
                        n_i  = r_i - 1'b1;
                        n_st = S_HFETCH;
                    end
                end
            end
            S_HCMP: begin
                hraddr = HIDX_W'(r_k - K_W'(3));
                if (r_m1 <= r_m2) begin
                    // non-left turn: drop the top vertex
                    n_k  = r_k - 1'b1;
                    n_b  = r_a;
                    n_st = S_HPOP;
                end else begin
                    // left turn: the point is kept on the next pass
                    n_keep = 1'b1;
                    n_st   = S_HTEST;
                end
            end
            S_HPOP: begin
                n_a  = r_hrd;
                n_st = S_HTEST;
            end
            S_ORD: begin
                n_st = S_OLD;
            end
            S_OLD: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_ovpt  = r_hrd;
                    n_olast = (K_W'(r_o) == r_len - 1'b1);
                    n_odrop = r_ovf;
                    if (K_W'(r_o) == r_len - 1'b1) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                        n_st  = S_IDLE;
                    end else begin
                        n_o  = r_o + 1'b1;
                        n_st = S_ORD;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_ov   <= 1'b0;
            r_keep <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            r_ov   <= n_ov;
            r_keep <= n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_close <= n_close;
        r_key   <= n_key;
        r_j     <= n_j;
        r_i     <= n_i;
        r_up    <= n_up;
        r_k     <= n_k;
        r_lim   <= n_lim;
        r_a     <= n_a;
        r_b     <= n_b;
        r_p     <= n_p;
        r_m1    <= n_m1;
        r_m2    <= n_m2;
        r_o     <= n_o;
        r_len   <= n_len;
        r_ovpt  <= n_ovpt;
        r_olast <= n_olast;
        r_odrop <= n_odrop;
    end

    always_ff @(posedge i_clk) begin
        if (pwe) begin
            r_pmem[pwaddr] <= pwdata;
        end
        r_prd <= r_pmem[praddr];
    end

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            r_hmem[HIDX_W'(r_k)] <= hwdata;
        end
        r_hrd <= r_hmem[hraddr];
    end

    assign o_hull.valid     = r_ov;
    assign o_hull.hull_y    = r_ovpt.y;
    assign o_hull.hull_z    = r_ovpt.z;
    assign o_hull.hull_last = r_olast;
    assign o_hull.dropped   = r_odrop;

endmodule

>>> rtl/core/convex_hull_2d.sv
// 2D convex hull (monotone chain). Points arrive one request at a time on i_pt;
// set_end closes a set. Up to MAX_POINTS points are kept, later ones are dropped
// and every vertex of that set carries dropped=1. Each stored point is placed by an
// insertion sort through the point memory, which has a registered read. On close the
// lower and upper chains are built; each cross-product test takes two 17x17
// multiplies, registered, and each non-left turn pops the top vertex of the chain.
// Vertices leave counter-clockwise, first vertex repeated at the end, read one by
// one from the hull memory; hull_last marks the final one. A set of one point
// gives that point, of two points p0,p1,p0.
// A 4-entry request queue lets new points be taken while the back end is busy.
module convex_hull_2d (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cvh_pt_if.sink     i_pt,
    cvh_hull_if.source o_hull
);
    import cvh_pkg::*;

    t_cmd   cmd;
    logic   cmd_valid;
    logic   cmd_ready;
    t_qstat qstat;

    cvh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pt        (i_pt),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_stat      (qstat)
    );

    cvh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_hull      (o_hull)
    );

    // Queue level tracks pushes and pops exactly.
    a_qlevel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        qstat.level == $past(qstat.level) + QLVL_W'($past(qstat.push))
                       - QLVL_W'($past(qstat.pop)))
        else $error("request queue level mismatch");

    // Queue never overfills.
    a_qbound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level <= QLVL_W'(QDEPTH))
        else $error("request queue overflow");

    // A vertex waiting for ready holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hull.valid && !o_hull.ready |=> o_hull.valid &&
        $stable({o_hull.hull_y, o_hull.hull_z, o_hull.hull_last, o_hull.dropped}))
        else $error("vertex changed while waiting");

endmodule

>>> bench/cvh_checker.sv
// Hull checker: predicts hull vertices from accepted point requests and compares results.
module cvh_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cvh_pt_if     pt,
    cvh_hull_if   hull,
    output int    o_fail_count,
    output int    o_vertices_due
);
    import cvh_pkg::*;

    typedef struct {
        t_coord y;
        t_coord z;
        logic   last;
        logic   dropped;
    } t_vertex;

    t_point  set_pts[$];
    logic    set_lost;
    t_vertex vertices_due[$];
    int      fails;

    assign o_fail_count   = fails;
    assign o_vertices_due = vertices_due.size();

    function automatic logic precedes(t_point a, t_point b);
        if (a.y != b.y) begin
            return a.y < b.y;
        end
        return a.z < b.z;
    endfunction

    // (a - o) x (b - o), exact in 64 bits
    function automatic longint turn(t_point o, t_point a, t_point b);
        longint ay, az, by, bz;
        ay = longint'(a.y) - longint'(o.y);
        az = longint'(a.z) - longint'(o.z);
        by = longint'(b.y) - longint'(o.y);
        bz = longint'(b.z) - longint'(o.z);
        return ay * bz - az * by;
    endfunction

    // Sort the collected set, run lower then upper chain, queue the vertices.
    task automatic predict_hull();
        t_point  srt[$];
        t_point  chain[$];
        t_point  key;
        t_vertex v;
        int      j;
        int      lim;
        srt = set_pts;
        for (int i = 1; i < srt.size(); i++) begin
            key = srt[i];
            j = i;
            while (j > 0 && precedes(key, srt[j-1])) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = key;
        end
        for (int i = 0; i < srt.size(); i++) begin
            while (chain.size() >= 2 &&
                   turn(chain[chain.size()-2], chain[chain.size()-1], srt[i]) <= 0)
                void'(chain.pop_back());
            chain.push_back(srt[i]);
        end
        lim = chain.size() + 1;
        for (int i = srt.size() - 2; i >= 0; i--) begin
            while (chain.size() >= lim &&
                   turn(chain[chain.size()-2], chain[chain.size()-1], srt[i]) <= 0)
                void'(chain.pop_back());
            chain.push_back(srt[i]);
        end
        foreach (chain[i]) begin
            v.y       = chain[i].y;
            v.z       = chain[i].z;
            v.last    = (i == chain.size() - 1);
            v.dropped = set_lost;
            vertices_due.push_back(v);
        end
    endtask

    always @(posedge i_clk) begin
        t_point  p;
        t_vertex e;
        if (!i_rst_n) begin
            set_pts.delete();
            vertices_due.delete();
            set_lost = 1'b0;
            fails    = 0;
        end else begin
            if (pt.valid && pt.ready) begin
                if (set_pts.size() < MAX_POINTS) begin
                    p.y = pt.point_y;
                    p.z = pt.point_z;
                    set_pts.push_back(p);
                end else begin
                    set_lost = 1'b1;
                end
                if (pt.set_end) begin
                    predict_hull();
                    set_pts.delete();
                    set_lost = 1'b0;
                end
            end
            if (hull.valid && hull.ready) begin
                if (vertices_due.size() == 0) begin
                    $error("unexpected hull vertex y=%0d z=%0d", hull.hull_y, hull.hull_z);
                    fails++;
                end else begin
                    e = vertices_due.pop_front();
                    if (hull.hull_y !== e.y) begin
                        $error("hull_y: expected %0d, got %0d", e.y, hull.hull_y);
                        fails++;
                    end
                    if (hull.hull_z !== e.z) begin
                        $error("hull_z: expected %0d, got %0d", e.z, hull.hull_z);
                        fails++;
                    end
                    if (hull.hull_last !== e.last) begin
                        $error("hull_last: expected %0b, got %0b", e.last, hull.hull_last);
                        fails++;
                    end
                    if (hull.dropped !== e.dropped) begin
                        $error("dropped: expected %0b, got %0b", e.dropped, hull.dropped);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

>>> bench/tb.sv
// Testbench top: clock, reset, point stimulus, result back-pressure and verdict.
module tb;
    import cvh_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_GOAL   = 120;

    logic i_clk;
    logic i_rst_n;
    int   phase;        // 0: receiver sparse, 1: sender sparse, 2: no idling
    int   points_sent;
    int   fail_count;
    int   vertices_due;
    int   cycles;

    cvh_pt_if   pt_ch();
    cvh_hull_if hull_ch();

    convex_hull_2d u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_hull  (hull_ch)
    );

    cvh_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .pt             (pt_ch),
        .hull           (hull_ch),
        .o_fail_count   (fail_count),
        .o_vertices_due (vertices_due)
    );

    // 8-unit clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: generous bound over the slowest legal run.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Result side back-pressure. Ready drops 64% of cycles in phase 0, 17% in
    // phase 1, never in phase 2 -- except one long hold when phase 2 opens, so
    // the request queue backs up and the block stalls its input.
    initial begin
        int  hold;
        bit  held;
        int  pct;
        hold = 0;
        held = 1'b0;
        hull_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase == 2 && !held) begin
                held = 1'b1;
                hold = 400;
            end
            pct = (phase == 0) ? 64 : (phase == 1) ? 17 : 0;
            if (hold > 0) begin
                hold--;
                hull_ch.ready <= 1'b0;
            end else begin
                hull_ch.ready <= ($urandom_range(99) >= pct);
            end
        end
    end

    // One point request; the sender may idle first depending on phase.
    task automatic send_point(input t_coord y, input t_coord z, input logic last);
        int pct;
        pct = (phase == 0) ? 17 : (phase == 1) ? 64 : 0;
        while ($urandom_range(99) < pct) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.point_y <= y;
        pt_ch.point_z <= z;
        pt_ch.set_end <= last;
        do @(posedge i_clk); while (!pt_ch.ready);
        points_sent++;
    endtask

    // Random set. Mostly small sets; now and then one near or past capacity so points
    // get dropped (set_end sometimes lands on a dropped point). Coordinates are
    // either full range or a tight grid, which breeds duplicates and collinear runs.
    task automatic send_random_set();
        int     n;
        bit     grid;
        t_coord y, z;
        n    = ($urandom_range(9) == 0) ? $urandom_range(MAX_POINTS + 4, MAX_POINTS - 2)
                                        : $urandom_range(8, 1);
        grid = $urandom_range(2) == 0;
        for (int i = 0; i < n; i++) begin
            if (grid) begin
                y = t_coord'(int'($urandom_range(6)) - 3);
                z = t_coord'(int'($urandom_range(6)) - 3);
            end else begin
                y = t_coord'($urandom);
                z = t_coord'($urandom);
            end
            send_point(y, z, i == n - 1);
        end
    endtask

    initial begin
        phase       = 0;
        points_sent = 0;
        i_rst_n       <= 1'b0;
        pt_ch.valid   <= 1'b0;
        pt_ch.point_y <= '0;
        pt_ch.point_z <= '0;
        pt_ch.set_end <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single point set: just that point back
        send_point(16'sh7FFF, -16'sh8000, 1'b1);
        // two points: p0,p1,p0
        send_point(-16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, -16'sh8000, 1'b1);
        // all duplicates collapse
        repeat (2) send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b1);
        // collinear run keeps only the ends
        for (int i = 0; i < 4; i++) send_point(t_coord'(i), t_coord'(i), i == 3);
        // extreme corners, interior point, point on an edge
        send_point(-16'sh8000, -16'sh8000, 1'b0);
        send_point(16'sh7FFF, -16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(-16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd0, -16'sh8000, 1'b1);

        while (points_sent < ITEM_GOAL) begin
            phase = (points_sent * 3) / ITEM_GOAL;
            send_random_set();
        end
        // last set always runs with nothing idling
        phase = 2;
        send_random_set();
        pt_ch.valid <= 1'b0;

        // let the checker see the closing request before draining
        @(posedge i_clk);
        while (vertices_due != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && vertices_due == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/cvh_pkg.sv
rtl/core/cvh_if.sv
rtl/core/cvh_front.sv
rtl/core/cvh_back.sv
rtl/core/convex_hull_2d.sv
bench/cvh_checker.sv
bench/tb.sv
